// ----- hdl/gcq_pkg.sv -----
package gcq_pkg;

    // Default sizes of the queue, the member map and the id fields.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAP_ENTRIES = 16;
    localparam int DEF_ID_WIDTH    = 16;
    localparam int DEF_GROUP_WIDTH = 8;

    // Fixed field widths on the stream ports.
    localparam int OP_W   = 2;
    localparam int SLOT_W = 4;
    localparam int FLAG_W = 2;

    // Bit positions of the result flags in the output tuser.
    localparam int FLAG_EMPTY = 0;
    localparam int FLAG_DROP  = 1;

    typedef enum logic [OP_W-1:0] {
        OP_MAP_WRITE = 2'd0,
        OP_ENQUEUE   = 2'd1,
        OP_DEQUEUE   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_FIND,
        ST_LOCATE,
        ST_COMMIT
    } t_state;

    // Per-cell load control for one commit cycle. At most one bit is set.
    typedef struct packed {
        logic load_new;
        logic from_left;
        logic from_right;
    } t_cell_ctl;

endpackage

// ----- hdl/gcq_cell.sv -----
module gcq_cell #(
    parameter int ID_WIDTH    = gcq_pkg::DEF_ID_WIDTH,
    parameter int GROUP_WIDTH = gcq_pkg::DEF_GROUP_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gcq_pkg::t_cell_ctl     i_ctl,
    input  logic [ID_WIDTH-1:0]    i_new_id,
    input  logic [GROUP_WIDTH-1:0] i_new_grp,
    input  logic [ID_WIDTH-1:0]    i_left_id,
    input  logic [GROUP_WIDTH-1:0] i_left_grp,
    input  logic [ID_WIDTH-1:0]    i_right_id,
    input  logic [GROUP_WIDTH-1:0] i_right_grp,
    input  logic                   i_right_member,
    input  logic [GROUP_WIDTH-1:0] i_match_grp,
    output logic [ID_WIDTH-1:0]    o_id,
    output logic [GROUP_WIDTH-1:0] o_grp,
    output logic                   o_valid,
    output logic                   o_member,
    output logic                   o_end
);

    logic [ID_WIDTH-1:0]    r_id;
    logic [ID_WIDTH-1:0]    n_id;
    logic [GROUP_WIDTH-1:0] r_grp;
    logic [GROUP_WIDTH-1:0] n_grp;

    always_comb begin
        n_id  = r_id;
        n_grp = r_grp;
        if (i_ctl.load_new) begin
            n_id  = i_new_id;
            n_grp = i_new_grp;
        end else if (i_ctl.from_left) begin
            n_id  = i_left_id;
            n_grp = i_left_grp;
        end else if (i_ctl.from_right) begin
            n_id  = i_right_id;
            n_grp = i_right_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id  <= '0;
            r_grp <= '0;
        end else begin
            r_id  <= n_id;
            r_grp <= n_grp;
        end
    end

    // A slot is a group member only while it holds an id; the last member of
    // a run is the one whose right neighbor is not a member.
    assign o_id     = r_id;
    assign o_grp    = r_grp;
    assign o_valid  = (r_id != '0);
    assign o_member = o_valid && (r_grp == i_match_grp);
    assign o_end    = o_member && !i_right_member;

endmodule

// ----- hdl/gcq_map.sv -----
module gcq_map #(
    parameter int MAP_ENTRIES = gcq_pkg::DEF_MAP_ENTRIES,
    parameter int ID_WIDTH    = gcq_pkg::DEF_ID_WIDTH,
    parameter int GROUP_WIDTH = gcq_pkg::DEF_GROUP_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [gcq_pkg::SLOT_W-1:0] i_wr_slot,
    input  logic [ID_WIDTH-1:0]       i_wr_id,
    input  logic [GROUP_WIDTH-1:0]    i_wr_grp,
    input  logic                      i_lk_load,
    input  logic [ID_WIDTH-1:0]       i_lk_id,
    output logic [GROUP_WIDTH-1:0]    o_lk_grp
);

    logic [ID_WIDTH-1:0]    r_map_id  [MAP_ENTRIES];
    logic [GROUP_WIDTH-1:0] r_map_grp [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] r_hit;
    logic [MAP_ENTRIES-1:0] first_hit;

    // Slots past the end of the table never decode, so such writes are lost.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAP_ENTRIES; k++) begin
                r_map_id[k]  <= '0;
                r_map_grp[k] <= '0;
            end
        end else if (i_wr_en) begin
            for (int k = 0; k < MAP_ENTRIES; k++) begin
                if (int'(i_wr_slot) == k) begin
                    r_map_id[k]  <= i_wr_id;
                    r_map_grp[k] <= i_wr_grp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lk_load) begin
            for (int k = 0; k < MAP_ENTRIES; k++) begin
                r_hit[k] <= (r_map_id[k] == i_lk_id);
            end
        end
    end

    // The lowest set hit bit picks the first matching entry; no hit gives 0.
    assign first_hit = r_hit & (~r_hit + MAP_ENTRIES'(1));

    always_comb begin
        o_lk_grp = '0;
        for (int k = 0; k < MAP_ENTRIES; k++) begin
            if (first_hit[k]) begin
                o_lk_grp = o_lk_grp | r_map_grp[k];
            end
        end
    end

endmodule

// ----- hdl/group_coalescing_queue.sv -----
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: item_id, group_id, map_slot
//                                                    tuser: operation
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: dequeued_id
//                                                    tuser: queue_was_empty, entry_dropped
//
// An enqueue of a nonzero id goes from acceptance to the next ready cycle through
// map compare, first-match select, slot locate and commit, each one register stage.
// Map writes, dequeues and all other items go from accept straight to commit.
// Synchronous active-low reset empties the queue and clears the map.
// A result waits in the output register; the commit of the next item stalls while
// that register is still full and m_axis_tready is low.
module group_coalescing_queue #(
    parameter int QUEUE_DEPTH = gcq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAP_ENTRIES = gcq_pkg::DEF_MAP_ENTRIES,
    parameter int ID_WIDTH    = gcq_pkg::DEF_ID_WIDTH,
    parameter int GROUP_WIDTH = gcq_pkg::DEF_GROUP_WIDTH,
    localparam int S_TDATA_W  = ((ID_WIDTH + GROUP_WIDTH + gcq_pkg::SLOT_W + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((ID_WIDTH + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0 up: item_id, group_id, map_slot, zero padding.
    input  logic [S_TDATA_W-1:0]         s_axis_tdata,
    // Fields from bit 0 up: operation.
    input  logic [gcq_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0 up: dequeued_id, zero padding.
    output logic [M_TDATA_W-1:0]         m_axis_tdata,
    // Fields from bit 0 up: queue_was_empty, entry_dropped.
    output logic [gcq_pkg::FLAG_W-1:0]   m_axis_tuser
);

    localparam int POS_W = $clog2(QUEUE_DEPTH);

    // Sequencer state.
    gcq_pkg::t_state r_state;
    gcq_pkg::t_state n_state;

    logic in_acc;
    logic out_free;
    logic commit_go;
    logic map_load;
    logic map_wr_en;

    // Fields of the item in progress.
    logic [gcq_pkg::OP_W-1:0]   r_op;
    logic [ID_WIDTH-1:0]        r_id;
    logic [GROUP_WIDTH-1:0]     r_grp_in;
    logic [gcq_pkg::SLOT_W-1:0] r_slot;

    // Group found for the enqueued id and the placement decision.
    logic [GROUP_WIDTH-1:0] r_grp;
    logic [GROUP_WIDTH-1:0] lk_grp;
    logic                   r_ins;
    logic [POS_W-1:0]       r_pos;
    logic                   r_drop;

    // Output register.
    logic                r_out_valid;
    logic [ID_WIDTH-1:0] r_out_id;
    logic                r_out_empty;
    logic                r_out_drop;

    // Cell row.
    logic [ID_WIDTH-1:0]    cell_id  [QUEUE_DEPTH];
    logic [GROUP_WIDTH-1:0] cell_grp [QUEUE_DEPTH];
    gcq_pkg::t_cell_ctl     cell_ctl [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [QUEUE_DEPTH-1:0] member_vec;
    logic [QUEUE_DEPTH-1:0] end_vec;

    // Locate results.
    logic             any_after;
    logic [POS_W-1:0] idx_after;
    logic             any_empty;
    logic [POS_W-1:0] idx_empty;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if ((s_axis_tuser == gcq_pkg::OP_ENQUEUE) &&
                        (s_axis_tdata[ID_WIDTH-1:0] != '0)) begin
                        n_state = gcq_pkg::ST_LOOK;
                    end else begin
                        n_state = gcq_pkg::ST_COMMIT;
                    end
                end
            end
            gcq_pkg::ST_LOOK:   n_state = gcq_pkg::ST_FIND;
            gcq_pkg::ST_FIND:   n_state = gcq_pkg::ST_LOCATE;
            gcq_pkg::ST_LOCATE: n_state = gcq_pkg::ST_COMMIT;
            gcq_pkg::ST_COMMIT: begin
                if (out_free) begin
                    n_state = gcq_pkg::ST_IDLE;
                end
            end
            default: n_state = gcq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        map_load      = 1'b0;
        commit_go     = 1'b0;
        case (r_state)
            gcq_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            gcq_pkg::ST_LOOK:   map_load      = 1'b1;
            gcq_pkg::ST_COMMIT: commit_go     = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Item capture and placement decision
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= s_axis_tuser;
            r_id     <= s_axis_tdata[ID_WIDTH-1:0];
            r_grp_in <= s_axis_tdata[ID_WIDTH +: GROUP_WIDTH];
            r_slot   <= s_axis_tdata[ID_WIDTH + GROUP_WIDTH +: gcq_pkg::SLOT_W];
        end
        if (r_state == gcq_pkg::ST_FIND) begin
            r_grp <= lk_grp;
        end
    end

    // Every queued group forms one unbroken run, so at most one cell flags the
    // end of the run. When that end sits in the last slot the new id is lost
    // and the queue stays as it is. Without a run the id goes to the first
    // empty slot, which is also slot 0 of an empty queue; a full queue drops it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins  <= 1'b0;
            r_drop <= 1'b0;
        end else if (in_acc) begin
            r_ins  <= 1'b0;
            r_drop <= 1'b0;
        end else if (r_state == gcq_pkg::ST_LOCATE) begin
            if (any_after) begin
                r_ins  <= 1'b1;
                r_pos  <= idx_after;
                r_drop <= valid_vec[QUEUE_DEPTH-1];
            end else if (end_vec[QUEUE_DEPTH-1]) begin
                r_ins  <= 1'b0;
                r_drop <= 1'b1;
            end else if (any_empty) begin
                r_ins  <= 1'b1;
                r_pos  <= idx_empty;
                r_drop <= 1'b0;
            end else begin
                r_ins  <= 1'b0;
                r_drop <= 1'b1;
            end
        end
    end

    // One-hot to index encoding of the slot after the run and of the first
    // empty slot.
    always_comb begin
        any_after = |end_vec[QUEUE_DEPTH-2:0];
        idx_after = '0;
        any_empty = 1'b0;
        idx_empty = '0;
        for (int k = 1; k < QUEUE_DEPTH; k++) begin
            if (end_vec[k-1]) begin
                idx_after = idx_after | POS_W'(k);
            end
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (!valid_vec[k] && ((k == 0) || valid_vec[(k == 0) ? 0 : k - 1])) begin
                any_empty = 1'b1;
                idx_empty = idx_empty | POS_W'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Member map
    // ------------------------------------------------------------------
    assign map_wr_en = commit_go && (r_op == gcq_pkg::OP_MAP_WRITE);

    gcq_map #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .ID_WIDTH    (ID_WIDTH),
        .GROUP_WIDTH (GROUP_WIDTH)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (map_wr_en),
        .i_wr_slot (r_slot),
        .i_wr_id   (r_id),
        .i_wr_grp  (r_grp_in),
        .i_lk_load (map_load),
        .i_lk_id   (r_id),
        .o_lk_grp  (lk_grp)
    );

    // ------------------------------------------------------------------
    // Cell row: on commit a dequeue moves every entry one slot toward the
    // head, and an insert loads the new id at its slot while the cells behind
    // it take their left neighbor's entry.
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            cell_ctl[k] = '0;
            if (commit_go) begin
                if (r_op == gcq_pkg::OP_DEQUEUE) begin
                    cell_ctl[k].from_right = 1'b1;
                end else if ((r_op == gcq_pkg::OP_ENQUEUE) && r_ins) begin
                    if (POS_W'(k) == r_pos) begin
                        cell_ctl[k].load_new = 1'b1;
                    end else if (POS_W'(k) > r_pos) begin
                        cell_ctl[k].from_left = 1'b1;
                    end
                end
            end
        end
    end

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic [ID_WIDTH-1:0]    left_id;
        logic [GROUP_WIDTH-1:0] left_grp;
        logic [ID_WIDTH-1:0]    right_id;
        logic [GROUP_WIDTH-1:0] right_grp;
        logic                   right_member;

        if (k == 0) begin : g_head
            assign left_id  = '0;
            assign left_grp = '0;
        end else begin : g_mid
            assign left_id  = cell_id[k-1];
            assign left_grp = cell_grp[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign right_id     = '0;
            assign right_grp    = '0;
            assign right_member = 1'b0;
        end else begin : g_body
            assign right_id     = cell_id[k+1];
            assign right_grp    = cell_grp[k+1];
            assign right_member = member_vec[k+1];
        end

        gcq_cell #(
            .ID_WIDTH    (ID_WIDTH),
            .GROUP_WIDTH (GROUP_WIDTH)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (cell_ctl[k]),
            .i_new_id       (r_id),
            .i_new_grp      (r_grp),
            .i_left_id      (left_id),
            .i_left_grp     (left_grp),
            .i_right_id     (right_id),
            .i_right_grp    (right_grp),
            .i_right_member (right_member),
            .i_match_grp    (r_grp),
            .o_id           (cell_id[k]),
            .o_grp          (cell_grp[k]),
            .o_valid        (valid_vec[k]),
            .o_member       (member_vec[k]),
            .o_end          (end_vec[k])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_go) begin
            r_out_id    <= (r_op == gcq_pkg::OP_DEQUEUE) ? cell_id[0] : '0;
            r_out_empty <= (r_op == gcq_pkg::OP_DEQUEUE) && !valid_vec[0];
            r_out_drop  <= (r_op == gcq_pkg::OP_ENQUEUE) && r_drop;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_id);
    always_comb begin
        m_axis_tuser                      = '0;
        m_axis_tuser[gcq_pkg::FLAG_EMPTY] = r_out_empty;
        m_axis_tuser[gcq_pkg::FLAG_DROP]  = r_out_drop;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Queued ids always fill the slots from the head with no gaps.
    a_queue_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (valid_vec[QUEUE_DEPTH-1:1] & ~valid_vec[QUEUE_DEPTH-2:0]) == '0)
        else $error("queue holds a gap between ids");

    // A group never splits, so the run end is unique when placing an id.
    a_single_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcq_pkg::ST_LOCATE) |-> $onehot0(end_vec))
        else $error("group members found in more than one run");

    // A new result appears only from a commit cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == gcq_pkg::ST_COMMIT))
        else $error("result raised outside a commit");

endmodule

// ----- dv/tb_group_coalescing_queue.sv -----
module tb_group_coalescing_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import gcq_pkg::*;

    localparam int QD    = DEF_QUEUE_DEPTH;
    localparam int ME    = DEF_MAP_ENTRIES;
    localparam int IDW   = DEF_ID_WIDTH;
    localparam int GW    = DEF_GROUP_WIDTH;
    localparam int S_W   = ((IDW + GW + SLOT_W + 7) / 8) * 8;
    localparam int M_W   = ((IDW + 7) / 8) * 8;

    // The one operation code that the block leaves unused.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam int IDLE_PCT       = 38;
    localparam int MAX_REPORTS    = 10;
    localparam int TAIL_CYCLES    = 12;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int MEMBER_POOL    = 8;

    // One expected result item, as the block should return it.
    typedef struct packed {
        logic [IDW-1:0] deq_id;
        logic           was_empty;
        logic           dropped;
    } t_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // Fields from bit 0 up: item_id, group_id, map_slot, zero padding.
    logic [S_W-1:0]   s_axis_tdata = '0;
    // Fields from bit 0 up: operation.
    logic [OP_W-1:0]  s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // Fields from bit 0 up: dequeued_id, zero padding.
    logic [M_W-1:0]   m_axis_tdata;
    // Fields from bit 0 up: queue_was_empty, entry_dropped.
    logic [FLAG_W-1:0] m_axis_tuser;

    group_coalescing_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow copy of the block's state. The queue lines hold the id and the
    // group that was looked up when the id went in; id 0 marks an empty line.
    logic [IDW-1:0] line_id  [QD];
    logic [GW-1:0]  line_grp [QD];
    logic [IDW-1:0] map_id   [ME];
    logic [GW-1:0]  map_grp  [ME];

    t_result pending_results[$];

    // Members used by the random tests, so that groups actually gather.
    logic [IDW-1:0] member_ids[MEMBER_POOL];

    // While set, neither side inserts idle cycles.
    logic        no_idle = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned n_map_writes   = 0;
    int unsigned n_enqueues     = 0;
    int unsigned n_dequeues     = 0;
    int unsigned n_ignored      = 0;
    int unsigned n_drops        = 0;
    int unsigned n_empty_deq    = 0;
    int unsigned n_tail_lost    = 0;

    // ------------------------------------------------------------------
    // Predictor of the team queue.
    // ------------------------------------------------------------------

    // The first map entry with a matching id wins; a miss gives group 0.
    function automatic logic [GW-1:0] group_of(logic [IDW-1:0] id);
        for (int k = 0; k < ME; k++) begin
            if (map_id[k] == id) return map_grp[k];
        end
        return '0;
    endfunction

    // A line past the end, or an empty line, is never a member of a group.
    function automatic logic line_in_group(int k, logic [GW-1:0] grp);
        if (k >= QD) return 1'b0;
        return (line_id[k] != '0) && (line_grp[k] == grp);
    endfunction

    // Places an id in the shadow queue and returns 1 when an id was lost.
    function automatic logic place_member(logic [IDW-1:0] id);
        logic [GW-1:0] grp;
        int            pos;
        logic          lost;
        grp = group_of(id);
        if (line_id[0] == '0) begin
            line_id[0]  = id;
            line_grp[0] = grp;
            return 1'b0;
        end
        for (int k = 0; k < QD; k++) begin
            if (line_in_group(k, grp) && !line_in_group(k + 1, grp)) begin
                // Goes right behind the last queued member of its group.
                pos = k + 1;
                if (pos >= QD) return 1'b1;
                lost = (line_id[QD-1] != '0);
                if (lost) n_tail_lost++;
                for (int m = QD - 1; m > pos; m--) begin
                    line_id[m]  = line_id[m-1];
                    line_grp[m] = line_grp[m-1];
                end
                line_id[pos]  = id;
                line_grp[pos] = grp;
                return lost;
            end
            if (line_id[k] == '0) begin
                // No member of the group is queued: first free line.
                line_id[k]  = id;
                line_grp[k] = grp;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_result team_queue_step(logic [OP_W-1:0] op, logic [IDW-1:0] id,
                                                logic [GW-1:0] grp, logic [SLOT_W-1:0] slot);
        t_result res;
        res = '0;
        if (op == OP_MAP_WRITE) begin
            n_map_writes++;
            if (int'(slot) < ME) begin
                map_id[slot]  = id;
                map_grp[slot] = grp;
            end
        end else if (op == OP_ENQUEUE) begin
            if (id != '0) begin
                n_enqueues++;
                res.dropped = place_member(id);
                if (res.dropped) n_drops++;
            end else begin
                n_ignored++;
            end
        end else if (op == OP_DEQUEUE) begin
            n_dequeues++;
            res.deq_id = line_id[0];
            res.was_empty = (line_id[0] == '0);
            if (res.was_empty) n_empty_deq++;
            for (int k = 0; k + 1 < QD; k++) begin
                line_id[k]  = line_id[k+1];
                line_grp[k] = line_grp[k+1];
            end
            line_id[QD-1]  = '0;
            line_grp[QD-1] = '0;
        end else begin
            n_ignored++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the per-item check.
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d, result %0d: %s expected 0x%0h, got 0x%0h",
                     cycle_count, results_seen, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch("no result pending, tdata", 0, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[IDW-1:0] !== want.deq_id)
                    note_mismatch("dequeued_id", want.deq_id, m_axis_tdata[IDW-1:0]);
                if (m_axis_tuser[FLAG_EMPTY] !== want.was_empty)
                    note_mismatch("queue_was_empty", want.was_empty, m_axis_tuser[FLAG_EMPTY]);
                if (m_axis_tuser[FLAG_DROP] !== want.dropped)
                    note_mismatch("entry_dropped", want.dropped, m_axis_tuser[FLAG_DROP]);
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Item side.
    // ------------------------------------------------------------------

    // Offers one item after a random gap, waits for the handshake and records
    // what the block should answer. Inputs only change at the falling edge.
    task automatic send_item(logic [OP_W-1:0] op, logic [IDW-1:0] id,
                             logic [GW-1:0] grp, logic [SLOT_W-1:0] slot);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = S_W'({slot, grp, id});
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(team_queue_step(op, id, grp, slot));
        items_sent++;
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic hold_until_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly queued members, some unmapped ids and a few extreme ones.
    function automatic logic [IDW-1:0] pick_id();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return member_ids[$urandom_range(0, MEMBER_POOL - 1)];
        if (roll < 95) return IDW'($urandom_range(1, (1 << IDW) - 1));
        return (roll < 98) ? {IDW{1'b1}} : IDW'(1);
    endfunction

    // A handful of groups so that members coalesce, now and then any group.
    function automatic logic [GW-1:0] pick_group();
        if ($urandom_range(0, 99) < 85) return GW'($urandom_range(0, 3));
        return GW'($urandom_range(0, (1 << GW) - 1));
    endfunction

    task automatic send_map_write();
        logic [IDW-1:0] id;
        id = ($urandom_range(0, 9) == 0) ? IDW'($urandom_range(0, (1 << IDW) - 1))
                                          : member_ids[$urandom_range(0, MEMBER_POOL - 1)];
        send_item(OP_MAP_WRITE, id, pick_group(), SLOT_W'($urandom_range(0, ME - 1)));
    endtask

    // Fields other than the operation are noise on a dequeue.
    task automatic send_dequeue();
        send_item(OP_DEQUEUE, IDW'($urandom), GW'($urandom), SLOT_W'($urandom));
    endtask

    task automatic send_enqueue(logic [IDW-1:0] id);
        send_item(OP_ENQUEUE, id, GW'($urandom), SLOT_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Dequeues from an empty queue, the unused operation code with every
    // field bit set, and an enqueue of id 0; none of them may touch state.
    task automatic test_idle_operations();
        send_item(OP_DEQUEUE, '0, '0, '0);
        send_item(OP_RESERVED, {IDW{1'b1}}, {GW{1'b1}}, {SLOT_W{1'b1}});
        send_item(OP_ENQUEUE, '0, {GW{1'b1}}, {SLOT_W{1'b1}});
        send_item(OP_DEQUEUE, {IDW{1'b1}}, {GW{1'b1}}, {SLOT_W{1'b1}});
    endtask

    // Lookup order, grouping, unmapped ids and the group cached at enqueue.
    task automatic test_group_ordering();
        // The same id in two map entries: the lower entry decides.
        send_item(OP_MAP_WRITE, {IDW{1'b1}}, {GW{1'b1}}, SLOT_W'(0));
        send_item(OP_MAP_WRITE, {IDW{1'b1}}, '0, SLOT_W'(1));
        send_item(OP_MAP_WRITE, IDW'(16'h0001), GW'(1), SLOT_W'(ME - 1));
        send_item(OP_MAP_WRITE, IDW'(16'h00AA), GW'(1), SLOT_W'(7));
        send_enqueue(IDW'(16'h0001));
        send_enqueue({IDW{1'b1}});
        send_enqueue(IDW'(16'h00AA));
        send_enqueue(IDW'(16'h1234));
        // Moving id 1 to another group leaves the copy already queued alone.
        send_item(OP_MAP_WRITE, IDW'(16'h0001), {GW{1'b1}}, SLOT_W'(ME - 1));
        send_enqueue(IDW'(16'h0001));
        send_enqueue(IDW'(16'h5555));
        repeat (7) send_dequeue();
    endtask

    // Fill bursts that overrun the queue, so that tails are lost, new ids are
    // refused and the last member sits in the final line; then partial drains.
    task automatic test_overflow_bursts();
        for (int b = 0; b < 6; b++) begin
            repeat ($urandom_range(2, 5)) send_map_write();
            repeat ($urandom_range(QD - 2, QD + 8)) send_enqueue(pick_id());
            repeat ($urandom_range(4, QD + 4)) send_dequeue();
            if (b == 2) hold_until_drained();
        end
    endtask

    // Blocks with a random enqueue share, so the fill level wanders between
    // empty and full, with a little noise mixed in.
    task automatic test_random_traffic();
        int unsigned enq_pct;
        int unsigned roll;
        for (int b = 0; b < 20; b++) begin
            enq_pct = $urandom_range(25, 75);
            no_idle = (b >= 8) && (b < 12);
            for (int n = 0; n < 50; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    send_item(OP_RESERVED, IDW'($urandom), GW'($urandom), SLOT_W'($urandom));
                else if (roll < 6)
                    send_item(OP_ENQUEUE, '0, GW'($urandom), SLOT_W'($urandom));
                else if (roll < 14)
                    send_map_write();
                else if (roll < 14 + (enq_pct * 86) / 100)
                    send_enqueue(pick_id());
                else
                    send_dequeue();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < QD; k++) begin
            line_id[k]  = '0;
            line_grp[k] = '0;
        end
        for (int k = 0; k < ME; k++) begin
            map_id[k]  = '0;
            map_grp[k] = '0;
        end
        for (int k = 0; k < MEMBER_POOL; k++)
            member_ids[k] = IDW'($urandom_range(1, (1 << IDW) - 1));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_operations();
        test_group_ordering();
        hold_until_drained();
        test_overflow_bursts();
        test_random_traffic();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d map writes, %0d enqueues, %0d dequeues, %0d ignored.",
                 items_sent, n_map_writes, n_enqueues, n_dequeues, n_ignored);
        $display("Saw %0d drops (%0d tail losses), %0d empty dequeues, %0d mismatches.",
                 n_drops, n_tail_lost, n_empty_deq, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/gcq_pkg.sv
hdl/gcq_cell.sv
hdl/gcq_map.sv
hdl/group_coalescing_queue.sv
dv/tb_group_coalescing_queue.sv
